// File: sv/mpsc_pkg.sv
// mixed path sea correction: shared types, widths and curve tables
// no dependencies; used by every module of the block
`default_nettype none

package mpsc_pkg;

  localparam int unsigned DistW  = 16;
  localparam int unsigned FracW  = 16;
  localparam int unsigned EndW   = 2;
  localparam int unsigned CorrW  = 12;
  localparam int unsigned SegW   = 4;
  localparam int unsigned OffW   = 13;
  localparam int unsigned SlopeW = 14;
  localparam int unsigned ProdW  = 27;
  localparam int unsigned SpanW  = 9;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [FracW-1:0] FracOne  = 16'd32768;
  localparam logic [DistW-1:0] Dist30   = 16'd480;
  localparam logic [DistW-1:0] Dist60   = 16'd960;
  localparam logic [SpanW-1:0] DistSpan = 9'd480;
  localparam logic [CorrW-1:0] CorrMax  = 12'd3840;

  typedef enum logic [EndW-1:0] {
    END_HIGH  = 2'd0,
    END_LOW   = 2'd1,
    END_EQUAL = 2'd2
  } sea_end_t;

  typedef logic [FracW-1:0]  bp_tab_t    [0:9];
  typedef logic [CorrW-1:0]  cv_tab_t    [0:9];
  typedef logic [SlopeW-1:0] slope_tab_t [0:8];

  localparam bp_tab_t BP30 = '{
    16'd0, 16'd4915, 16'd11469, 16'd14746, 16'd19661,
    16'd21299, 16'd23757, 16'd25395, 16'd27853, 16'd32768};
  localparam bp_tab_t BP60 = '{
    16'd0, 16'd4915, 16'd9830, 16'd13107, 16'd16384,
    16'd19661, 16'd23757, 16'd27853, 16'd29491, 16'd32768};

  localparam cv_tab_t CV30_HIGH = '{
    12'd0, 12'd256, 12'd768, 12'd1024, 12'd1536,
    12'd1792, 12'd2048, 12'd2304, 12'd2560, 12'd2816};
  localparam cv_tab_t CV30_LOW = '{
    12'd0, 12'd1024, 12'd1408, 12'd1792, 12'd2176,
    12'd2304, 12'd2432, 12'd2509, 12'd2624, 12'd2816};
  localparam cv_tab_t CV60_HIGH = '{
    12'd0, 12'd512, 12'd1024, 12'd1408, 12'd1792,
    12'd2304, 12'd2816, 12'd3328, 12'd3584, 12'd3840};
  localparam cv_tab_t CV60_LOW = '{
    12'd0, 12'd1088, 12'd1600, 12'd2355, 12'd2688,
    12'd3008, 12'd3328, 12'd3584, 12'd3648, 12'd3840};

  // per-segment slopes, 1/256 dB per q1.15 step, q16
  localparam slope_tab_t SL30_HIGH = '{
    14'd3413, 14'd5120, 14'd5120, 14'd6827, 14'd10243,
    14'd6826, 14'd10243, 14'd6826, 14'd3413};
  localparam slope_tab_t SL30_LOW = '{
    14'd13654, 14'd3840, 14'd7680, 14'd5120, 14'd5121,
    14'd3413, 14'd3081, 14'd3066, 14'd2560};
  localparam slope_tab_t SL60_HIGH = '{
    14'd6827, 14'd6827, 14'd7680, 14'd7680, 14'd10239,
    14'd8192, 14'd8192, 14'd10243, 14'd5120};
  localparam slope_tab_t SL60_LOW = '{
    14'd14507, 14'd6827, 14'd15099, 14'd6660, 14'd6400,
    14'd5120, 14'd4096, 14'd2561, 14'd3840};

  // segment index: number of inner breakpoints strictly below the fraction
  function automatic logic [SegW-1:0] seg_find(input logic [FracW-1:0] frac,
                                               input bp_tab_t bp);
    logic [SegW-1:0] cnt;
    cnt = '0;
    for (int k = 1; k <= 8; k++) begin
      cnt = cnt + SegW'(frac > bp[k]);
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

// File: sv/mpsc_blend.sv
// mixed path sea correction: distance blend of the 30 km and 60 km values
// three register stages with per-stage stall; uses mpsc_pkg
`default_nettype none

module mpsc_blend (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [mpsc_pkg::CorrW-1:0] v30,
  input  wire logic [mpsc_pkg::CorrW-1:0] v60,
  input  wire logic [mpsc_pkg::SpanW-1:0] span,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [mpsc_pkg::CorrW-1:0]      corr
);
  import mpsc_pkg::*;

  localparam int unsigned MagProdW = CorrW + SpanW;
  localparam int unsigned QuotW    = 16;
  localparam int unsigned RecipW   = 32;
  localparam logic [QuotW-1:0] Recip15 = 16'd34953;

  logic                vld1, vld2, vld3;
  logic                en1, en2, en3;

  logic [MagProdW-1:0] b1_prod;
  logic                b1_neg;
  logic [CorrW-1:0]    b1_base;

  logic [RecipW-1:0]   b2_qprod;
  logic                b2_neg;
  logic [CorrW-1:0]    b2_base;

  logic [CorrW-1:0]    mag;
  logic [MagProdW-1:0] rounded;
  logic [QuotW-1:0]    shifted;
  logic [CorrW:0]      quot;
  logic [CorrW:0]      res;

  assign en3      = !vld3 || out_ready;
  assign en2      = !vld2 || en3;
  assign en1      = !vld1 || en2;
  assign in_ready = en1;

  assign mag     = (v60 >= v30) ? (v60 - v30) : (v30 - v60);
  // divide by 480: shift right by 5 (divide by 32), then multiply by the reciprocal of 15
  assign rounded = b1_prod + MagProdW'(DistSpan >> 1);
  assign shifted = QuotW'(rounded >> 5);
  assign quot    = b2_qprod[RecipW-1 -: (CorrW + 1)];
  assign res     = b2_neg ? ({1'b0, b2_base} - quot) : ({1'b0, b2_base} + quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (en1) vld1 <= in_valid;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
    end
    if (en1) begin
      b1_prod <= MagProdW'(mag) * MagProdW'(span);
      b1_neg  <= v60 < v30;
      b1_base <= v30;
    end
    if (en2) begin
      b2_qprod <= RecipW'(shifted) * RecipW'(Recip15);
      b2_neg   <= b1_neg;
      b2_base  <= b1_base;
    end
    if (en3) begin
      corr <= (res > {1'b0, CorrMax}) ? CorrMax : res[CorrW-1:0];
    end
  end

  assign out_valid = vld3;

endmodule

`default_nettype wire

// File: sv/mixed_path_sea_correction.sv
// mixed path sea correction: top level, curve lookup and interpolation stages
// depends on mpsc_pkg and mpsc_blend
//
//  channel  dir  word layout (lsb first)
//  s_*      in   distance_km[15:0] sea_fraction[31:16] sea_end[33:32] zero[39:34]
//  m_*      out  correction_db[11:0] zero[15:12]
//
// one word per cycle sustained while m_tready is high
// the register stages, in order: segment search, table lookup,
// curve multiply, curve sum, blend multiply, reciprocal multiply, result
// reset clears the valid bits only; payload registers are not reset
// a stall holds each full stage; empty stages keep filling behind it
`default_nettype none

module mixed_path_sea_correction (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // distance_km, sea_fraction, sea_end, zero pad
  input  wire logic [mpsc_pkg::InDataW-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // correction_db, zero pad
  output logic [mpsc_pkg::OutDataW-1:0]      m_tdata
);
  import mpsc_pkg::*;

  logic [DistW-1:0]  in_dist;
  logic [FracW-1:0]  in_frac;
  logic [EndW-1:0]   in_end;
  logic [FracW-1:0]  frac_sat;
  logic [SpanW-1:0]  span_in;

  logic              vld1, vld2, vld3, vld4;
  logic              en1, en2, en3, en4;
  logic              blend_ready;

  logic [FracW-1:0]  s1_frac;
  logic [SegW-1:0]   s1_seg30, s1_seg60;
  logic [EndW-1:0]   s1_end;
  logic [SpanW-1:0]  s1_span;

  logic [OffW-1:0]   s2_off30, s2_off60;
  logic [SlopeW-1:0] s2_sl30h, s2_sl30l, s2_sl60h, s2_sl60l;
  logic [CorrW-1:0]  s2_c30h, s2_c30l, s2_c60h, s2_c60l;
  logic [EndW-1:0]   s2_end;
  logic [SpanW-1:0]  s2_span;

  logic [ProdW-1:0]  s3_p30h, s3_p30l, s3_p60h, s3_p60l;
  logic [CorrW-1:0]  s3_c30h, s3_c30l, s3_c60h, s3_c60l;
  logic [EndW-1:0]   s3_end;
  logic [SpanW-1:0]  s3_span;

  logic [CorrW-1:0]  s4_v30, s4_v60;
  logic [SpanW-1:0]  s4_span;

  logic [CorrW-1:0]  v30h, v30l, v60h, v60l;
  logic [CorrW:0]    sum30, sum60;
  logic [CorrW-1:0]  v30_sel, v60_sel;
  logic [CorrW-1:0]  corr;

  assign in_dist = s_tdata[DistW-1:0];
  assign in_frac = s_tdata[DistW +: FracW];
  assign in_end  = s_tdata[DistW + FracW +: EndW];

  assign frac_sat = (in_frac > FracOne) ? FracOne : in_frac;
  always_comb begin
    priority if (in_dist <= Dist30) begin
      span_in = '0;
    end else if (in_dist >= Dist60) begin
      span_in = DistSpan;
    end else begin
      span_in = SpanW'(in_dist - Dist30);
    end
  end

  assign en4      = !vld4 || blend_ready;
  assign en3      = !vld3 || en4;
  assign en2      = !vld2 || en3;
  assign en1      = !vld1 || en2;
  assign s_tready = en1;

  function automatic logic [CorrW-1:0] curve_val(input logic [CorrW-1:0] c0,
                                                 input logic [ProdW-1:0] p);
    logic [ProdW-1:0] r;
    r = p + ProdW'(32'd32768);
    return c0 + CorrW'(r >> 16);
  endfunction

  assign v30h  = curve_val(s3_c30h, s3_p30h);
  assign v30l  = curve_val(s3_c30l, s3_p30l);
  assign v60h  = curve_val(s3_c60h, s3_p60h);
  assign v60l  = curve_val(s3_c60l, s3_p60l);
  assign sum30 = {1'b0, v30h} + {1'b0, v30l} + (CorrW+1)'(1);
  assign sum60 = {1'b0, v60h} + {1'b0, v60l} + (CorrW+1)'(1);

  always_comb begin
    unique case (s3_end)
      END_HIGH: begin
        v30_sel = v30h;
        v60_sel = v60h;
      end
      END_LOW: begin
        v30_sel = v30l;
        v60_sel = v60l;
      end
      default: begin
        v30_sel = sum30[CorrW:1];
        v60_sel = sum60[CorrW:1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else begin
      if (en1) vld1 <= s_tvalid;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
      if (en4) vld4 <= vld3;
    end
    // segment search
    if (en1) begin
      s1_frac  <= frac_sat;
      s1_seg30 <= seg_find(frac_sat, BP30);
      s1_seg60 <= seg_find(frac_sat, BP60);
      s1_end   <= in_end;
      s1_span  <= span_in;
    end
    // offsets, slopes and segment base values
    if (en2) begin
      s2_off30 <= OffW'(s1_frac - BP30[s1_seg30]);
      s2_off60 <= OffW'(s1_frac - BP60[s1_seg60]);
      s2_sl30h <= SL30_HIGH[s1_seg30];
      s2_sl30l <= SL30_LOW[s1_seg30];
      s2_sl60h <= SL60_HIGH[s1_seg60];
      s2_sl60l <= SL60_LOW[s1_seg60];
      s2_c30h  <= CV30_HIGH[s1_seg30];
      s2_c30l  <= CV30_LOW[s1_seg30];
      s2_c60h  <= CV60_HIGH[s1_seg60];
      s2_c60l  <= CV60_LOW[s1_seg60];
      s2_end   <= s1_end;
      s2_span  <= s1_span;
    end
    // slope products
    if (en3) begin
      s3_p30h <= ProdW'(s2_off30) * ProdW'(s2_sl30h);
      s3_p30l <= ProdW'(s2_off30) * ProdW'(s2_sl30l);
      s3_p60h <= ProdW'(s2_off60) * ProdW'(s2_sl60h);
      s3_p60l <= ProdW'(s2_off60) * ProdW'(s2_sl60l);
      s3_c30h <= s2_c30h;
      s3_c30l <= s2_c30l;
      s3_c60h <= s2_c60h;
      s3_c60l <= s2_c60l;
      s3_end  <= s2_end;
      s3_span <= s2_span;
    end
    // curve values for the chosen end
    if (en4) begin
      s4_v30  <= v30_sel;
      s4_v60  <= v60_sel;
      s4_span <= s3_span;
    end
  end

  mpsc_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld4),
    .in_ready  (blend_ready),
    .v30       (s4_v30),
    .v60       (s4_v60),
    .span      (s4_span),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .corr      (corr)
  );

  assign m_tdata = {(OutDataW - CorrW)'(0), corr};

endmodule

`default_nettype wire

// File: sv/mpsc_checker.sv
// mixed path sea correction: port-level checks over time
// bound to mixed_path_sea_correction; uses mpsc_pkg
`default_nettype none

module mpsc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [mpsc_pkg::OutDataW-1:0] m_tdata
);
  import mpsc_pkg::*;

  // a held output word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // correction within range, pad bits clear
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[CorrW-1:0] <= CorrMax) &&
                 (m_tdata[OutDataW-1:CorrW] == '0))
    else $error("correction word out of range");

  // with the output stage empty the whole pipe can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind mixed_path_sea_correction mpsc_checker u_mpsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: verif/mixed_path_sea_correction_test.sv
// testbench for mixed_path_sea_correction: directed table then random queries,
// each result word checked against a typed value or a built-in curve and blend predictor
// depends on mpsc_pkg for port widths and sea end codes

module mixed_path_sea_correction_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpsc_pkg::InDataW;
  import mpsc_pkg::OutDataW;
  import mpsc_pkg::END_HIGH;
  import mpsc_pkg::END_LOW;
  import mpsc_pkg::END_EQUAL;

  localparam logic [1:0] EndSpare = 2'd3;
  localparam int unsigned DistNear  = 480;
  localparam int unsigned DistFar   = 960;
  localparam int unsigned DistBlend = 480;
  localparam int unsigned FracFull  = 32768;
  localparam int unsigned CorrCeil  = 3840;
  localparam int unsigned RandItems = 1900;
  localparam int unsigned CycleLimit = 200000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [15:0] distance;
    logic [15:0] frac;
    logic [1:0]  sea_end;
    bit          typed;
    logic [11:0] corr;
  } query_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  idle_mode_t idle_mode = IDLE_NONE;
  logic [11:0] corr_due[$];
  logic [11:0] corr_want;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // breakpoints index [far][point], curve values index [far][end][point]
  int unsigned knee [2][10] = '{
    '{0, 4915, 11469, 14746, 19661, 21299, 23757, 25395, 27853, 32768},
    '{0, 4915, 9830, 13107, 16384, 19661, 23757, 27853, 29491, 32768}};
  int unsigned curve [2][2][10] = '{
    '{'{0, 256, 768, 1024, 1536, 1792, 2048, 2304, 2560, 2816},
      '{0, 1024, 1408, 1792, 2176, 2304, 2432, 2509, 2624, 2816}},
    '{'{0, 512, 1024, 1408, 1792, 2304, 2816, 3328, 3584, 3840},
      '{0, 1088, 1600, 2355, 2688, 3008, 3328, 3584, 3648, 3840}}};

  query_row_t plan [20] = '{
    '{16'd0,     16'd0,     END_HIGH,  1'b1, 12'd0},
    '{16'd65535, 16'd0,     END_EQUAL, 1'b1, 12'd0},
    '{16'd700,   16'd0,     EndSpare,  1'b1, 12'd0},
    '{16'd0,     16'd32768, END_HIGH,  1'b1, 12'd2816},
    '{16'd480,   16'd32768, END_LOW,   1'b1, 12'd2816},
    '{16'd960,   16'd32768, END_HIGH,  1'b1, 12'd3840},
    '{16'd65535, 16'd65535, END_LOW,   1'b1, 12'd3840},
    '{16'd0,     16'd32769, END_EQUAL, 1'b1, 12'd2816},
    '{16'd0,     16'd65535, EndSpare,  1'b1, 12'd2816},
    '{16'd0,     16'd4915,  END_HIGH,  1'b1, 12'd256},
    '{16'd0,     16'd4915,  END_LOW,   1'b1, 12'd1024},
    '{16'd0,     16'd1,     END_HIGH,  1'b0, 12'd0},
    '{16'd960,   16'd9830,  END_HIGH,  1'b0, 12'd0},
    '{16'd960,   16'd9831,  END_LOW,   1'b0, 12'd0},
    '{16'd720,   16'd16384, END_HIGH,  1'b0, 12'd0},
    '{16'd720,   16'd16384, END_LOW,   1'b0, 12'd0},
    '{16'd720,   16'd16384, END_EQUAL, 1'b0, 12'd0},
    '{16'd720,   16'd16384, EndSpare,  1'b0, 12'd0},
    '{16'd481,   16'd20000, END_EQUAL, 1'b0, 12'd0},
    '{16'd959,   16'd30000, END_LOW,   1'b0, 12'd0}};

  mixed_path_sea_correction dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned curve_at(input int far, input int low_end,
                                           input int seg, input int unsigned frac);
    int unsigned w;
    int unsigned slope;
    int unsigned off;
    w = knee[far][seg+1] - knee[far][seg];
    slope = ((curve[far][low_end][seg+1] - curve[far][low_end][seg]) * 65536 + w / 2) / w;
    off = frac - knee[far][seg];
    return curve[far][low_end][seg] + ((off * slope + 32768) >> 16);
  endfunction

  function automatic int unsigned distance_curve(input int far, input int unsigned frac,
                                                 input logic [1:0] sea_end);
    int seg;
    seg = 0;
    while (seg < 8 && frac > knee[far][seg+1]) seg++;
    if (sea_end == END_HIGH) return curve_at(far, 0, seg, frac);
    if (sea_end == END_LOW) return curve_at(far, 1, seg, frac);
    return (curve_at(far, 0, seg, frac) + curve_at(far, 1, seg, frac) + 1) >> 1;
  endfunction

  function automatic logic [11:0] sea_correction(input logic [15:0] distance,
                                                 input logic [15:0] frac_in,
                                                 input logic [1:0] sea_end);
    int unsigned frac;
    int unsigned near_v;
    int unsigned far_v;
    int unsigned t;
    int unsigned corr;
    frac = (frac_in > FracFull) ? FracFull : frac_in;
    if (frac == 0) begin
      corr = 0;
    end else if (distance <= DistNear) begin
      corr = distance_curve(0, frac, sea_end);
    end else if (distance >= DistFar) begin
      corr = distance_curve(1, frac, sea_end);
    end else begin
      near_v = distance_curve(0, frac, sea_end);
      far_v = distance_curve(1, frac, sea_end);
      t = distance - DistNear;
      if (far_v >= near_v)
        corr = near_v + ((far_v - near_v) * t + DistBlend / 2) / DistBlend;
      else
        corr = near_v - ((near_v - far_v) * t + DistBlend / 2) / DistBlend;
    end
    if (corr > CorrCeil) corr = CorrCeil;
    return corr[11:0];
  endfunction

  task automatic send_query(input logic [15:0] distance, input logic [15:0] frac,
                            input logic [1:0] sea_end, input logic [11:0] corr);
    bit took;
    took = 1'b0;
    s_tvalid <= 1'b1;
    s_tdata <= {{(InDataW-34){1'b0}}, sea_end, frac, distance};
    while (!took) begin
      @(negedge clk);
      took = s_tready;
      if (took) corr_due.push_back(corr);
      @(posedge clk);
    end
  endtask

  task automatic sender_gap();
    int unsigned pct;
    pct = (idle_mode == IDLE_SENDER) ? 58 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    while ($urandom_range(0, 99) < pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= InDataW'({$urandom, $urandom});
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: m_tready <= ($urandom_range(0, 99) >= 58);
      IDLE_BOTH:     m_tready <= ($urandom_range(0, 99) >= 26);
      default:       m_tready <= 1'b1;
    endcase
  end

  // handshake values are sampled at the falling edge, before the rising edge that takes them
  always @(negedge clk) begin
    if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (corr_due.size() == 0) begin
        $error("correction_db: expected none, actual %0d", m_tdata[11:0]);
        mismatches++;
      end else begin
        corr_want = corr_due.pop_front();
        if (m_tdata[11:0] !== corr_want) begin
          $error("correction_db: expected %0d, actual %0d", corr_want, m_tdata[11:0]);
          mismatches++;
        end
        if (m_tdata[OutDataW-1:12] !== '0) begin
          $error("pad: expected 0, actual %0h", m_tdata[OutDataW-1:12]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [15:0] distance;
    logic [15:0] frac;
    logic [1:0]  sea_end;
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_query(plan[i].distance, plan[i].frac, plan[i].sea_end,
                 plan[i].typed ? plan[i].corr
                               : sea_correction(plan[i].distance, plan[i].frac,
                                                plan[i].sea_end));
    end

    for (int ph = 0; ph < 8; ph++) begin
      // sender holds off until the pipeline has drained
      s_tvalid <= 1'b0;
      while (corr_due.size() != 0) @(posedge clk);
      idle_mode <= idle_mode_t'(ph % 4);
      @(posedge clk);
      for (int n = 0; n < RandItems / 8; n++) begin
        case ($urandom_range(0, 3))
          0:       distance = 16'($urandom_range(0, DistNear));
          1:       distance = 16'($urandom_range(DistNear + 1, DistFar - 1));
          2:       distance = 16'($urandom_range(DistFar, 65535));
          default: distance = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0: frac = 16'd0;
          1: frac = 16'($urandom);
          2: begin
            k = $urandom_range(0, 9);
            frac = 16'(knee[$urandom_range(0, 1)][k] + $urandom_range(0, 2) - 1);
          end
          default: frac = 16'($urandom_range(1, FracFull));
        endcase
        sea_end = 2'($urandom_range(0, 3));
        sender_gap();
        send_query(distance, frac, sea_end, sea_correction(distance, frac, sea_end));
      end
    end

    s_tvalid <= 1'b0;
    idle_mode <= IDLE_NONE;
    while (corr_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
